// ----- rtl/tsb_pkg.sv -----
// Shared types, constants and helpers for the bilinear wrap texture sampler.
package tsb_pkg;

  // Field and datapath widths
  localparam int unsigned COORD_W      = 24;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned SUB_BITS     = 8;
  localparam int unsigned DIM_W        = 9;
  localparam int unsigned MAX_DIM      = 256;
  localparam int unsigned XY_W         = 8;
  localparam int unsigned TEXEL_W      = 32;
  localparam int unsigned IDX_W        = 16;
  localparam int unsigned STORE_TEXELS = 65536;
  localparam int unsigned POS_W        = FRAC_BITS + DIM_W;
  localparam int unsigned SUBW_W       = SUB_BITS + 1;
  localparam int unsigned WT_W         = 2 * SUB_BITS + 1;
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned ACC_W        = WT_W + CHAN_W;
  localparam int unsigned OUT_W        = 16;
  localparam int unsigned OUT_RSH      = 2 * SUB_BITS - 8;
  localparam int unsigned BEAT_W       = 2;
  localparam int unsigned NUM_CH       = 4;

  localparam logic [SUBW_W-1:0] SUB_ONE     = SUBW_W'(1) << SUB_BITS;
  localparam logic [BEAT_W-1:0] LAST_BEAT_BI = BEAT_W'(3);
  localparam logic [BEAT_W-1:0] LAST_BEAT_1  = BEAT_W'(0);

  // Command codes; the fourth code is unused and dropped on entry
  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_NEAREST  = 2'd1,
    CMD_BILINEAR = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } cfg_reg_e;

  // Word after address generation, ready for the issue stage
  typedef struct packed {
    cmd_e                 cmd;
    logic [IDX_W-1:0]     idx;
    logic [TEXEL_W-1:0]   val;
    logic [XY_W-1:0]      x1;
    logic [XY_W-1:0]      x2;
    logic [IDX_W-1:0]     row1;
    logic [IDX_W-1:0]     row2;
    logic [SUB_BITS-1:0]  fu;
    logic [SUB_BITS-1:0]  fv;
  } addr_item_t;

  // One memory read beat handed to the blend unit
  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last;
    logic [WT_W-1:0] wt;
  } beat_t;

  // Pipeline advance controls for the address front end
  typedef struct packed {
    logic p1_take;
    logic p2_take;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic [OUT_W-1:0] alpha;
  } color_t;

  // Zero acts as one, oversize clamps to the largest dimension
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// ----- rtl/texture_sampler_bilinear_wrap.sv -----
// Top level of the wrap-addressed texture sampler with nearest and bilinear filtering.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------------------
//   input   | in        | in_valid_i / in_stall_o  | cmd, texel_index/value, coord_u/v
//   output  | out       | out_valid_o / out_stall_i| red, green, blue, alpha (Q8.8)
//   config  | in        | cfg_we_i, no wait        | cfg_index_i, cfg_wdata_i
//
// Write and nearest words make one store access each at the issue stage; bilinear
// makes 4, one texel read per cycle while the pipe is not frozen, on the single
// read port of the texel store.
// Reset clears pipeline valids and sets both sizes to 1; the store is not cleared.
// A stalled output freezes the pipe only once the next result is ready to load.
module texture_sampler_bilinear_wrap (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         cmd_i,
  input  logic [tsb_pkg::IDX_W-1:0]          texel_index_i,
  input  logic [tsb_pkg::TEXEL_W-1:0]        texel_value_i,
  input  logic signed [tsb_pkg::COORD_W-1:0] coord_u_i,
  input  logic signed [tsb_pkg::COORD_W-1:0] coord_v_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tsb_pkg::OUT_W-1:0]          red_o,
  output logic [tsb_pkg::OUT_W-1:0]          green_o,
  output logic [tsb_pkg::OUT_W-1:0]          blue_o,
  output logic [tsb_pkg::OUT_W-1:0]          alpha_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [tsb_pkg::DIM_W-1:0]          cfg_wdata_i
);
  import tsb_pkg::*;

  logic [DIM_W-1:0]   eff_w_q, eff_h_q;
  pipe_ctrl_t         ctrl;
  logic               p1_take, p2_take;
  logic               p1_valid, p2_valid;
  addr_item_t         p2_item;
  addr_item_t         p3_q;
  logic               p3_valid_q;
  logic [BEAT_W-1:0]  step_q;
  logic [BEAT_W-1:0]  last_step;
  logic               s3_done, s3_take, adv;
  logic               is_wr;
  logic [XY_W-1:0]    x_sel;
  logic [IDX_W-1:0]   row_sel, rd_addr;
  logic [SUBW_W-1:0]  fu_w, fv_w;
  logic [2*SUBW_W-1:0] wt_full;
  beat_t              beat;
  logic               wr_en, rd_en;
  logic [TEXEL_W-1:0] rdata;
  color_t             color;

  // Size registers hold the effective (clamped) dimension
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= DIM_W'(1);
      eff_h_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TEX_WIDTH:  eff_w_q <= eff_dim(cfg_wdata_i);
        REG_TEX_HEIGHT: eff_h_q <= eff_dim(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Pipe advance: issue stage holds a bilinear word until its last beat
  assign last_step    = (p3_q.cmd == CMD_BILINEAR) ? LAST_BEAT_BI : LAST_BEAT_1;
  assign s3_done      = p3_valid_q && (step_q == last_step);
  assign s3_take      = adv && (!p3_valid_q || s3_done);
  assign p2_take      = adv && (!p2_valid || s3_take);
  assign p1_take      = adv && (!p1_valid || p2_take);
  assign ctrl         = '{p1_take: p1_take, p2_take: p2_take};
  assign in_stall_o   = !p1_take;

  tsb_addr u_addr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .cmd_i         (cmd_i),
    .texel_index_i (texel_index_i),
    .texel_value_i (texel_value_i),
    .coord_u_i     (coord_u_i),
    .coord_v_i     (coord_v_i),
    .eff_w_i       (eff_w_q),
    .eff_h_i       (eff_h_q),
    .ctrl_i        (ctrl),
    .p1_valid_o    (p1_valid),
    .p2_valid_o    (p2_valid),
    .p2_item_o     (p2_item)
  );

  // Issue stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
      step_q     <= '0;
    end else if (s3_take) begin
      p3_valid_q <= p2_valid;
      step_q     <= '0;
    end else if (adv && p3_valid_q) begin
      step_q     <= step_q + BEAT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_take) begin
      p3_q <= p2_item;
    end
  end

  // Beat order: (x1,y1) (x2,y1) (x1,y2) (x2,y2)
  always_comb begin
    is_wr   = (p3_q.cmd == CMD_WRITE);
    x_sel   = step_q[0] ? p3_q.x2 : p3_q.x1;
    row_sel = step_q[1] ? p3_q.row2 : p3_q.row1;
    rd_addr = IDX_W'(x_sel) + row_sel;
    fu_w    = step_q[0] ? SUBW_W'(p3_q.fu) : SUB_ONE - SUBW_W'(p3_q.fu);
    fv_w    = step_q[1] ? SUBW_W'(p3_q.fv) : SUB_ONE - SUBW_W'(p3_q.fv);
    wt_full = (2*SUBW_W)'(fu_w) * (2*SUBW_W)'(fv_w);
    beat.valid = p3_valid_q && !is_wr;
    beat.first = (step_q == '0);
    beat.last  = s3_done;
    beat.wt    = wt_full[WT_W-1:0];
  end

  // Writes and reads leave in word order, so a read always follows an earlier write
  assign wr_en = adv && p3_valid_q && is_wr;
  assign rd_en = adv && p3_valid_q && !is_wr;

  tsb_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (p3_q.idx),
    .wr_data_i (p3_q.val),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rdata)
  );

  tsb_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .rdata_i     (rdata),
    .out_stall_i (out_stall_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .color_o     (color)
  );

  assign red_o   = color.red;
  assign green_o = color.green;
  assign blue_o  = color.blue;
  assign alpha_o = color.alpha;

endmodule

// ----- rtl/tsb_addr.sv -----
// Address front end: coordinate wrap, texel position, neighbor and row offsets.
module tsb_addr (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [1:0]                    cmd_i,
  input  logic [tsb_pkg::IDX_W-1:0]     texel_index_i,
  input  logic [tsb_pkg::TEXEL_W-1:0]   texel_value_i,
  input  logic signed [tsb_pkg::COORD_W-1:0] coord_u_i,
  input  logic signed [tsb_pkg::COORD_W-1:0] coord_v_i,
  input  logic [tsb_pkg::DIM_W-1:0]     eff_w_i,
  input  logic [tsb_pkg::DIM_W-1:0]     eff_h_i,
  input  tsb_pkg::pipe_ctrl_t           ctrl_i,
  output logic                          p1_valid_o,
  output logic                          p2_valid_o,
  output tsb_pkg::addr_item_t           p2_item_o
);
  import tsb_pkg::*;

  typedef struct packed {
    cmd_e                cmd;
    logic [IDX_W-1:0]    idx;
    logic [TEXEL_W-1:0]  val;
    logic [XY_W-1:0]     x1;
    logic [XY_W-1:0]     y1;
    logic [SUB_BITS-1:0] fu;
    logic [SUB_BITS-1:0] fv;
  } loc_t;

  logic [POS_W-1:0]     pos_u, pos_v;
  logic                 known_cmd;
  loc_t                 p1_d, p1_q;
  logic                 p1_valid_q;
  addr_item_t           p2_d, p2_q;
  logic                 p2_valid_q;
  logic [XY_W-1:0]      y2;
  logic [2*DIM_W-1:0]   row1_full, row2_full;

  // Stage 1: scale the coordinate fraction by the texture size
  always_comb begin
    pos_u     = POS_W'(coord_u_i[FRAC_BITS-1:0]) * POS_W'(eff_w_i);
    pos_v     = POS_W'(coord_v_i[FRAC_BITS-1:0]) * POS_W'(eff_h_i);
    known_cmd = (cmd_i == CMD_WRITE) || (cmd_i == CMD_NEAREST) || (cmd_i == CMD_BILINEAR);
    p1_d.cmd  = cmd_e'(cmd_i);
    p1_d.idx  = texel_index_i;
    p1_d.val  = texel_value_i;
    p1_d.x1   = pos_u[FRAC_BITS +: XY_W];
    p1_d.y1   = pos_v[FRAC_BITS +: XY_W];
    // nearest uses full weight on the first texel
    p1_d.fu   = (cmd_i == CMD_BILINEAR) ? pos_u[FRAC_BITS-1 -: SUB_BITS] : '0;
    p1_d.fv   = (cmd_i == CMD_BILINEAR) ? pos_v[FRAC_BITS-1 -: SUB_BITS] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (ctrl_i.p1_take) begin
      p1_valid_q <= in_valid_i && known_cmd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.p1_take) begin
      p1_q <= p1_d;
    end
  end

  // Stage 2: wrapped neighbors and row offsets
  always_comb begin
    p2_d.cmd  = p1_q.cmd;
    p2_d.idx  = p1_q.idx;
    p2_d.val  = p1_q.val;
    p2_d.x1   = p1_q.x1;
    p2_d.x2   = ({1'b0, p1_q.x1} == eff_w_i - DIM_W'(1)) ? '0 : p1_q.x1 + XY_W'(1);
    y2        = ({1'b0, p1_q.y1} == eff_h_i - DIM_W'(1)) ? '0 : p1_q.y1 + XY_W'(1);
    row1_full = (2*DIM_W)'(p1_q.y1) * (2*DIM_W)'(eff_w_i);
    row2_full = (2*DIM_W)'(y2) * (2*DIM_W)'(eff_w_i);
    p2_d.row1 = row1_full[IDX_W-1:0];
    p2_d.row2 = row2_full[IDX_W-1:0];
    p2_d.fu   = p1_q.fu;
    p2_d.fv   = p1_q.fv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (ctrl_i.p2_take) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.p2_take) begin
      p2_q <= p2_d;
    end
  end

  assign p1_valid_o = p1_valid_q;
  assign p2_valid_o = p2_valid_q;
  assign p2_item_o  = p2_q;

endmodule

// ----- rtl/tsb_mem.sv -----
// Texel store: one write port and one registered read port.
module tsb_mem (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [tsb_pkg::IDX_W-1:0]     wr_addr_i,
  input  logic [tsb_pkg::TEXEL_W-1:0]   wr_data_i,
  input  logic                          rd_en_i,
  input  logic [tsb_pkg::IDX_W-1:0]     rd_addr_i,
  output logic [tsb_pkg::TEXEL_W-1:0]   rd_data_o
);
  import tsb_pkg::*;

  logic [TEXEL_W-1:0] mem_q [STORE_TEXELS];
  logic [TEXEL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data held while the pipe is frozen
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/tsb_filter.sv -----
// Blend unit: per-channel multiply-accumulate over texel beats and output register.
module tsb_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsb_pkg::beat_t                beat_i,
  input  logic [tsb_pkg::TEXEL_W-1:0]   rdata_i,
  input  logic                          out_stall_i,
  output logic                          adv_o,
  output logic                          out_valid_o,
  output tsb_pkg::color_t               color_o
);
  import tsb_pkg::*;

  beat_t              beat_q;
  logic [ACC_W-1:0]   acc_q [NUM_CH];
  logic [ACC_W-1:0]   sum   [NUM_CH];
  logic [CHAN_W-1:0]  chan  [NUM_CH];
  logic               out_valid_q;
  color_t             color_q;
  logic               adv;
  logic               fire;

  // Freeze the whole pipe only when a finished word has nowhere to go
  assign adv  = !(beat_q.valid && beat_q.last && out_valid_q && out_stall_i);
  assign fire = adv && beat_q.valid;

  // Channel order red, green, blue, alpha from an ARGB word
  always_comb begin
    chan[0] = rdata_i[23:16];
    chan[1] = rdata_i[15:8];
    chan[2] = rdata_i[7:0];
    chan[3] = rdata_i[31:24];
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c] = (beat_q.first ? '0 : acc_q[c])
             + ACC_W'(ACC_W'(chan[c]) * ACC_W'(beat_q.wt));
    end
  end

  // Beat register sits beside the memory read register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (adv) begin
      beat_q <= beat_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int c = 0; c < NUM_CH; c++) begin
        acc_q[c] <= sum[c];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && beat_q.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && beat_q.last) begin
      color_q.red   <= sum[0][OUT_RSH +: OUT_W];
      color_q.green <= sum[1][OUT_RSH +: OUT_W];
      color_q.blue  <= sum[2][OUT_RSH +: OUT_W];
      color_q.alpha <= sum[3][OUT_RSH +: OUT_W];
    end
  end

  assign adv_o       = adv;
  assign out_valid_o = out_valid_q;
  assign color_o     = color_q;

endmodule

// ----- rtl/tsb_checker.sv -----
// Port-level checker for the texture sampler, bound to the top level.
module tsb_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [1:0]                         cmd_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [tsb_pkg::OUT_W-1:0]          red_o,
  input logic [tsb_pkg::OUT_W-1:0]          green_o,
  input logic [tsb_pkg::OUT_W-1:0]          blue_o,
  input logic [tsb_pkg::OUT_W-1:0]          alpha_o
);
  import tsb_pkg::*;

  localparam logic [OUT_W-1:0] OUT_MAX  = OUT_W'(16'hFF00);
  localparam logic [3:0]       MAX_PEND = 4'd5;

  logic       smp_in, smp_out;
  logic [3:0] pend_q;

  // Samples in flight: accepted sample words minus delivered results
  assign smp_in  = in_valid_i && !in_stall_o
                && (cmd_i == CMD_NEAREST || cmd_i == CMD_BILINEAR);
  assign smp_out = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(smp_in) - 4'(smp_out);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_o) && $stable(green_o)
      && $stable(blue_o) && $stable(alpha_o))
    else $error("stalled result word changed");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> red_o <= OUT_MAX && green_o <= OUT_MAX
      && blue_o <= OUT_MAX && alpha_o <= OUT_MAX)
    else $error("blended channel above full scale");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result word without a pending sample");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MAX_PEND)
    else $error("more samples in flight than pipeline slots");

endmodule

bind texture_sampler_bilinear_wrap tsb_checker u_tsb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o),
  .alpha_o     (alpha_o)
);
